### rtl/core/file_allocation_table_engine_core_assert.svh
// assertion macros shared by the rtl
`ifndef FILE_ALLOCATION_TABLE_ENGINE_CORE_ASSERT_SVH
`define FILE_ALLOCATION_TABLE_ENGINE_CORE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define FATE_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define FATE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/fate_pkg.sv
package fate_pkg;

  localparam int unsigned TableDepth  = 256;
  localparam int unsigned LinkWidth   = 8;
  localparam int unsigned SectorCount = 256;
  localparam logic [7:0]  EndMark     = 8'hFF;

  typedef enum logic [2:0] {
    REQ_NEW    = 3'd0,
    REQ_SIZE   = 3'd1,
    REQ_APPEND = 3'd2,
    REQ_LOCATE = 3'd3,
    REQ_FORMAT = 3'd4
  } req_e;

  // one request word
  typedef struct packed {
    logic [7:0] position;
    logic [7:0] file_num;
    logic [2:0] req_type;
  } req_t;

  // one result word
  typedef struct packed {
    logic [7:0] value;
    logic       status;
  } res_t;

  // single-port table access
  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

endpackage

### rtl/core/fate_ram.sv
module fate_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

### rtl/core/fate_ctrl.sv
module fate_ctrl #(
  parameter int unsigned NumSectors = fate_pkg::SectorCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fate_pkg::req_t    req_i,
  output logic              ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output fate_pkg::res_t    res_o,
  output fate_pkg::mem_req_t dir_req_o,
  input  logic [7:0]        dir_rdata_i,
  output fate_pkg::mem_req_t link_req_o,
  input  logic [7:0]        link_rdata_i
);
  import fate_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NEW, S_SZ_HEAD, S_SZ_WALK, S_LC_HEAD, S_LC_WALK,
    S_AP_DIR, S_AP_WALK, S_AP_CHECK, S_AP_HEAD, S_AP_TAIL, S_DONE
  } state_e;

  localparam logic [8:0] WalkLimit = 9'(TableDepth);
  localparam logic [8:0] FullMark  = 9'(NumSectors - 1);

  state_e     state_q, state_d;
  logic       fmt_q, fmt_d;
  req_t       req_q, req_d;
  logic [7:0] slot_q, slot_d;
  logic [7:0] s_q, s_d;
  logic [8:0] cnt_q, cnt_d;
  logic [7:0] hi_q, hi_d;
  logic       hiv_q, hiv_d;
  logic [7:0] free_q, free_d;
  res_t       res_q, res_d;

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // sequencer: one access to each table per cycle, the next request waits for the result
  always_comb begin
    state_d    = state_q;
    fmt_d      = fmt_q;
    req_d      = req_q;
    slot_d     = slot_q;
    s_d        = s_q;
    cnt_d      = cnt_q;
    hi_d       = hi_q;
    hiv_d      = hiv_q;
    free_d     = free_q;
    res_d      = res_q;
    dir_req_o  = '{we: 1'b0, addr: slot_q, wdata: EndMark};
    link_req_o = '{we: 1'b0, addr: s_q, wdata: EndMark};
    case (state_q)
      S_CLEAR: begin
        dir_req_o.we  = 1'b1;
        link_req_o.we = 1'b1;
        link_req_o.addr = slot_q;
        slot_d = slot_q + 8'd1;
        if (slot_q == EndMark) begin
          if (fmt_q) begin
            res_d   = '{value: 8'd0, status: 1'b0};
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
          fmt_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          req_d  = req_i;
          slot_d = 8'd0;
          hiv_d  = 1'b0;
          case (req_i.req_type)
            REQ_NEW, REQ_APPEND: begin
              dir_req_o.addr = 8'd0;
              state_d = (req_i.req_type == REQ_NEW) ? S_NEW : S_AP_DIR;
            end
            REQ_SIZE, REQ_LOCATE: begin
              dir_req_o.addr = req_i.file_num;
              state_d = (req_i.req_type == REQ_SIZE) ? S_SZ_HEAD : S_LC_HEAD;
            end
            REQ_FORMAT: begin
              fmt_d   = 1'b1;
              state_d = S_CLEAR;
            end
            default: begin
              res_d   = '{value: EndMark, status: 1'b1};
              state_d = S_DONE;
            end
          endcase
        end
      end
      // first empty directory slot
      S_NEW: begin
        if (dir_rdata_i == EndMark) begin
          res_d   = '{value: slot_q, status: 1'b0};
          state_d = S_DONE;
        end else if (slot_q == 8'd254) begin
          res_d   = '{value: EndMark, status: 1'b1};
          state_d = S_DONE;
        end else begin
          slot_d = slot_q + 8'd1;
          dir_req_o.addr = slot_q + 8'd1;
        end
      end
      // chain length, saturating
      S_SZ_HEAD: begin
        if (dir_rdata_i == EndMark) begin
          res_d   = '{value: 8'd0, status: 1'b0};
          state_d = S_DONE;
        end else begin
          cnt_d = 9'd1;
          link_req_o.addr = dir_rdata_i;
          state_d = S_SZ_WALK;
        end
      end
      S_SZ_WALK: begin
        if (link_rdata_i == EndMark || cnt_q == 9'd255) begin
          res_d   = '{value: cnt_q[7:0], status: 1'b0};
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 9'd1;
          link_req_o.addr = link_rdata_i;
        end
      end
      // follow the chain to the position
      S_LC_HEAD: begin
        if (req_q.position == 8'd0 || dir_rdata_i == EndMark) begin
          res_d   = '{value: dir_rdata_i, status: (dir_rdata_i == EndMark)};
          state_d = S_DONE;
        end else begin
          cnt_d = 9'd1;
          link_req_o.addr = dir_rdata_i;
          state_d = S_LC_WALK;
        end
      end
      S_LC_WALK: begin
        if (cnt_q == {1'b0, req_q.position} || link_rdata_i == EndMark) begin
          res_d   = '{value: link_rdata_i, status: (link_rdata_i == EndMark)};
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 9'd1;
          link_req_o.addr = link_rdata_i;
        end
      end
      // scan files for the highest tail
      S_AP_DIR: begin
        if (dir_rdata_i == EndMark) begin
          free_d  = hiv_q ? hi_q + 8'd1 : 8'd0;
          state_d = S_AP_CHECK;
        end else begin
          s_d   = dir_rdata_i;
          cnt_d = 9'd0;
          link_req_o.addr = dir_rdata_i;
          state_d = S_AP_WALK;
        end
      end
      S_AP_WALK: begin
        if (link_rdata_i == EndMark || cnt_q == WalkLimit) begin
          if (!hiv_q || s_q > hi_q) begin
            hi_d = s_q;
          end
          hiv_d = 1'b1;
          if (slot_q == 8'd254) begin
            free_d  = EndMark;
            state_d = S_AP_CHECK;
          end else begin
            slot_d = slot_q + 8'd1;
            dir_req_o.addr = slot_q + 8'd1;
            state_d = S_AP_DIR;
          end
        end else begin
          s_d   = link_rdata_i;
          cnt_d = cnt_q + 9'd1;
          link_req_o.addr = link_rdata_i;
        end
      end
      S_AP_CHECK: begin
        if ({1'b0, free_q} >= FullMark) begin
          res_d   = '{value: EndMark, status: 1'b1};
          state_d = S_DONE;
        end else begin
          dir_req_o.addr = req_q.file_num;
          state_d = S_AP_HEAD;
        end
      end
      S_AP_HEAD: begin
        res_d = '{value: free_q, status: 1'b0};
        if (dir_rdata_i == EndMark) begin
          dir_req_o = '{we: 1'b1, addr: req_q.file_num, wdata: free_q};
          state_d   = S_DONE;
        end else begin
          s_d   = dir_rdata_i;
          cnt_d = 9'd0;
          link_req_o.addr = dir_rdata_i;
          state_d = S_AP_TAIL;
        end
      end
      // link the new sector behind the tail
      S_AP_TAIL: begin
        if (link_rdata_i == EndMark || cnt_q == WalkLimit) begin
          link_req_o = '{we: 1'b1, addr: s_q, wdata: free_q};
          state_d    = S_DONE;
        end else begin
          s_d   = link_rdata_i;
          cnt_d = cnt_q + 9'd1;
          link_req_o.addr = link_rdata_i;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and the registers with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fmt_q   <= 1'b0;
      slot_q  <= 8'd0;
      hiv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fmt_q   <= fmt_d;
      slot_q  <= slot_d;
      hiv_q   <= hiv_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    s_q    <= s_d;
    cnt_q  <= cnt_d;
    hi_q   <= hi_d;
    free_q <= free_d;
    res_q  <= res_d;
  end

endmodule

### rtl/core/file_allocation_table_engine_core.sv
// file allocation table engine
// requests come in on the s_axis channel, one result word per request leaves
// on the m_axis channel. request kinds: new file, size, append sector,
// locate sector, format; unknown kinds return failure with value 255.
// the directory and the link table each live in a single-port ram with a
// registered read; the sequencer does one access to each table per cycle,
// and the result word passes through an output register to m_axis once the
// sequencer finishes. a new file scans the directory for an empty slot,
// size and locate walk one chain, append walks the chains of every file in
// use, and format sweeps both tables to 255.
// one request is in flight at a time; s_axis_tready_o is high only while the
// sequencer is idle. the result sits in an output register, so a new request
// is taken while an earlier result waits; a stalled m_axis holds the word and
// the following result then waits in the sequencer for the register to free.
// after reset both tables are swept to 255, one entry per cycle, and no
// request is accepted until the sweep ends.
module file_allocation_table_engine_core #(
  parameter int unsigned NumSectors = fate_pkg::SectorCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // req_type[2:0], file_num[10:3], position[18:11]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // status[0], value[8:1]
);
  import fate_pkg::*;

  `include "file_allocation_table_engine_core_assert.svh"

  logic     ctrl_ready, res_valid, res_ready, res_load, start;
  req_t     req;
  res_t     res, out_q;
  logic     out_valid_q;
  mem_req_t dir_req, link_req;
  logic [LinkWidth-1:0] dir_rdata, link_rdata;

  assign req             = s_axis_tdata_i[18:0];
  assign s_axis_tready_o = ctrl_ready;
  assign start           = s_axis_tvalid_i & ctrl_ready;
  assign res_ready       = !out_valid_q || m_axis_tready_i;
  assign res_load        = res_valid & res_ready;

  fate_ctrl #(.NumSectors(NumSectors)) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i      (start),
    .req_i        (req),
    .ready_o      (ctrl_ready),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .dir_req_o    (dir_req),
    .dir_rdata_i  (dir_rdata),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata)
  );

  fate_ram #(.Width(LinkWidth), .Depth(TableDepth)) u_dir_ram (
    .clk_i,
    .we_i    (dir_req.we),
    .addr_i  (dir_req.addr),
    .wdata_i (dir_req.wdata),
    .rdata_o (dir_rdata)
  );

  fate_ram #(.Width(LinkWidth), .Depth(TableDepth)) u_link_ram (
    .clk_i,
    .we_i    (link_req.we),
    .addr_i  (link_req.addr),
    .wdata_i (link_req.wdata),
    .rdata_o (link_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q};

  // sequencer never finishes and accepts in the same cycle
  `FATE_ASSERT(a_done_not_idle, clk_i, rst_ni, res_valid, !s_axis_tready_o)
  // an accepted request occupies the sequencer
  `FATE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, start, !s_axis_tready_o)
  // a finished result shows up on the output
  `FATE_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, res_load, m_axis_tvalid_o)

endmodule
